// ===== hdl/mfsp_pkg.sv =====
package mfsp_pkg;

	typedef enum logic [3:0] {
		PH_HDR       = 4'd0,
		PH_TRK_HDR   = 4'd1,
		PH_DELTA     = 4'd2,
		PH_STATUS    = 4'd3,
		PH_META_TYPE = 4'd4,
		PH_META_LEN  = 4'd5,
		PH_META_BODY = 4'd6,
		PH_SYSEX_LEN = 4'd7,
		PH_SYSEX_BODY = 4'd8,
		PH_DATA1     = 4'd9,
		PH_DATA2     = 4'd10,
		PH_SKIP      = 4'd11,
		PH_HALT      = 4'd12
	} phase_t;

	localparam logic [3:0] EV_HEADER     = 4'd0;
	localparam logic [3:0] EV_HDR_ERR    = 4'd1;
	localparam logic [3:0] EV_TRK_START  = 4'd2;
	localparam logic [3:0] EV_MARK_ERR   = 4'd3;
	localparam logic [3:0] EV_TEMPO      = 4'd4;
	localparam logic [3:0] EV_TIMESIG    = 4'd5;
	localparam logic [3:0] EV_KEYSIG     = 4'd6;
	localparam logic [3:0] EV_TRK_END    = 4'd7;
	localparam logic [3:0] EV_CHANNEL    = 4'd8;
	localparam logic [3:0] EV_SKIPPED    = 4'd9;
	localparam logic [3:0] EV_VLQ_ERR    = 4'd10;
	localparam logic [3:0] EV_STATUS_ERR = 4'd11;

	localparam logic [7:0] META_STATUS  = 8'hFF;
	localparam logic [7:0] META_TEMPO   = 8'h51;
	localparam logic [7:0] META_TIMESIG = 8'h58;
	localparam logic [7:0] META_KEYSIG  = 8'h59;
	localparam logic [7:0] META_EOT     = 8'h2F;
	localparam logic [7:0] SYSEX_F0     = 8'hF0;
	localparam logic [7:0] SYSEX_F7     = 8'hF7;

	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 88;

	typedef struct packed {
		logic [3:0]  event_kind;
		logic [27:0] delta_ticks;
		logic [7:0]  status_code;
		logic [31:0] payload;
		logic [15:0] division;
	} result_t;

	function automatic logic [7:0] hdr_magic(input logic [1:0] i);
		unique case (i)
			2'd0: hdr_magic = 8'h4d;
			2'd1: hdr_magic = 8'h54;
			2'd2: hdr_magic = 8'h68;
			default: hdr_magic = 8'h64;
		endcase
	endfunction

	function automatic logic [7:0] trk_magic(input logic [1:0] i);
		unique case (i)
			2'd0: trk_magic = 8'h4d;
			2'd1: trk_magic = 8'h54;
			2'd2: trk_magic = 8'h72;
			default: trk_magic = 8'h6b;
		endcase
	endfunction

	function automatic logic [2:0] meta_std_len(input logic [7:0] t);
		if (t == META_TEMPO) meta_std_len = 3'd3;
		else if (t == META_TIMESIG) meta_std_len = 3'd4;
		else if (t == META_KEYSIG) meta_std_len = 3'd2;
		else meta_std_len = 3'd0;
	endfunction

endpackage

// ===== hdl/mfsp_core.sv =====
module mfsp_core
	import mfsp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic          in_start,
	output logic          res_valid,
	output result_t       res
);

	phase_t      phase_q, ph, ph_n;
	logic [3:0]  fbc_q, fbc, fbc_n;
	logic [31:0] tbl_q, tbl, tbl_n;
	logic [15:0] trl_q, trl, trl_n;
	logic [27:0] vacc_q, vacc, vacc_n;
	logic [2:0]  vcnt_q, vcnt, vcnt_n;
	logic [27:0] hdel_q, hdel, hdel_n;
	logic [7:0]  rs_q, rs, rs_n;
	logic [7:0]  mt_q, mt, mt_n;
	logic [31:0] bbl_q, bbl, bbl_n;
	logic [31:0] cw_q, cw, cw_n;
	logic [47:0] hw_q, hw, hw_n;

	logic        vflag;
	logic [1:0]  vres;
	logic [27:0] vval, vacc_sh;
	logic [2:0]  vcnt_inc;
	logic [31:0] bbl_dec;
	logic [3:0]  mkind;
	logic        one_db;
	logic [7:0]  b;

	always_comb begin
		b = in_byte;
		ph = phase_q; fbc = fbc_q; tbl = tbl_q; trl = trl_q; vacc = vacc_q;
		vcnt = vcnt_q; hdel = hdel_q; rs = rs_q; mt = mt_q; bbl = bbl_q; cw = cw_q;
		hw = hw_q;
		if (in_start) begin
			ph = PH_HDR; fbc = '0; tbl = '0; trl = '0; vacc = '0; vcnt = '0;
			hdel = '0; rs = '0; mt = '0; bbl = '0; cw = '0; hw = '0;
		end
		ph_n = ph; fbc_n = fbc; trl_n = trl; vacc_n = vacc; vcnt_n = vcnt;
		hdel_n = hdel; rs_n = rs; mt_n = mt; bbl_n = bbl; cw_n = cw; hw_n = hw;
		tbl_n = tbl;
		if (ph >= PH_DELTA && ph <= PH_SKIP && tbl != '0) tbl_n = tbl - 32'd1;
		res_valid = 1'b0;
		res = '0;

		// vlq step
		vacc_sh = {vacc[20:0], b[6:0]};
		vcnt_inc = vcnt + 3'd1;
		vval = vacc_sh;
		vres = 2'd0;
		if (!b[7]) vres = 2'd1;
		else if (vcnt_inc >= 3'd4) vres = 2'd2;

		one_db = (rs[7:4] == 4'hC) || (rs[7:4] == 4'hD);
		bbl_dec = (bbl != '0) ? bbl - 32'd1 : bbl;
		vflag = 1'b0;

		// meta completion kind (cw_n resolved per phase)
		mkind = EV_SKIPPED;
		if (mt == META_TEMPO) mkind = EV_TEMPO;
		else if (mt == META_TIMESIG) mkind = EV_TIMESIG;
		else if (mt == META_KEYSIG) mkind = EV_KEYSIG;
		else if (mt == META_EOT) mkind = EV_TRK_END;

		unique case (ph)
			PH_HDR: begin
				if (fbc < 4'd4 && b != hdr_magic(fbc[1:0])) begin
					res_valid = 1'b1;
					res.event_kind = EV_HDR_ERR;
					ph_n = PH_HALT;
				end else begin
					if (fbc >= 4'd8) hw_n = {hw[39:0], b};
					if (fbc >= 4'd13) begin
						res_valid = 1'b1;
						res.event_kind = EV_HEADER;
						res.payload = hw_n[47:16];
						res.division = hw_n[15:0];
						trl_n = hw_n[31:16];
						fbc_n = '0;
						ph_n = (hw_n[31:16] == '0) ? PH_HALT : PH_TRK_HDR;
					end else fbc_n = fbc + 4'd1;
				end
			end
			PH_TRK_HDR: begin
				if (fbc < 4'd4 && b != trk_magic(fbc[1:0])) begin
					res_valid = 1'b1;
					res.event_kind = EV_MARK_ERR;
					ph_n = PH_HALT;
				end else begin
					if (fbc >= 4'd4) cw_n = {cw[23:0], b};
					if (fbc >= 4'd7) begin
						tbl_n = cw_n;
						res_valid = 1'b1;
						res.event_kind = EV_TRK_START;
						res.payload = cw_n;
						rs_n = '0; hdel_n = '0; vacc_n = '0; vcnt_n = '0; fbc_n = '0;
						if (cw_n == '0) vflag = 1'b1;
						else ph_n = PH_DELTA;
					end else fbc_n = fbc + 4'd1;
				end
			end
			PH_DELTA: begin
				vacc_n = vacc_sh; vcnt_n = vcnt_inc;
				if (vres == 2'd1) begin
					vacc_n = '0; vcnt_n = '0; hdel_n = vval; ph_n = PH_STATUS;
				end else if (vres == 2'd2) begin
					vacc_n = '0; vcnt_n = '0;
					res_valid = 1'b1;
					res.event_kind = EV_VLQ_ERR;
					ph_n = PH_SKIP;
				end
			end
			PH_STATUS: begin
				res.delta_ticks = hdel;
				if (b == META_STATUS) begin
					rs_n = '0; ph_n = PH_META_TYPE;
				end else if (b == SYSEX_F0 || b == SYSEX_F7) begin
					rs_n = '0; mt_n = b; ph_n = PH_SYSEX_LEN;
				end else if (b[7] && b < 8'hF0) begin
					rs_n = b; ph_n = PH_DATA1;
				end else if (b[7] || rs == '0) begin
					res_valid = 1'b1;
					res.event_kind = EV_STATUS_ERR;
					res.status_code = b[7] ? b : 8'd0;
					res.payload = {24'd0, b};
					vacc_n = '0; vcnt_n = '0;
					ph_n = PH_SKIP;
				end else begin
					cw_n = {24'd0, b};
					if (one_db) begin
						res_valid = 1'b1;
						res.event_kind = EV_CHANNEL;
						res.status_code = rs;
						res.payload = {16'd0, b, 8'd0};
						ph_n = PH_DELTA;
					end else ph_n = PH_DATA2;
				end
			end
			PH_DATA1, PH_DATA2: begin
				res.delta_ticks = hdel;
				res.status_code = rs;
				if (b[7]) begin
					res_valid = 1'b1;
					res.event_kind = EV_STATUS_ERR;
					res.payload = {24'd0, b};
					vacc_n = '0; vcnt_n = '0;
					ph_n = PH_SKIP;
				end else if (ph == PH_DATA1 && !one_db) begin
					cw_n = {24'd0, b}; ph_n = PH_DATA2;
				end else begin
					res_valid = 1'b1;
					res.event_kind = EV_CHANNEL;
					res.payload = (ph == PH_DATA1) ? {16'd0, b, 8'd0}
						: {16'd0, 1'b0, cw[6:0], b};
					ph_n = PH_DELTA;
				end
			end
			PH_META_TYPE: begin
				mt_n = b; ph_n = PH_META_LEN;
			end
			PH_META_LEN: begin
				vacc_n = vacc_sh; vcnt_n = vcnt_inc;
				res.delta_ticks = hdel;
				if (vres == 2'd1) begin
					vacc_n = '0; vcnt_n = '0;
					bbl_n = {4'd0, vval}; fbc_n = '0;
					cw_n = (meta_std_len(mt) != 3'd0) ? 32'd0 : {4'd0, vval};
					if (vval == '0) begin
						res_valid = 1'b1;
						res.event_kind = mkind;
						res.status_code = mt;
						res.payload = (mkind == EV_TRK_END) ? 32'd0 : cw_n;
						ph_n = PH_DELTA;
						if (mkind == EV_TRK_END) ph_n = PH_SKIP;
					end else ph_n = PH_META_BODY;
				end else if (vres == 2'd2) begin
					vacc_n = '0; vcnt_n = '0;
					res_valid = 1'b1;
					res.event_kind = EV_VLQ_ERR;
					res.status_code = META_STATUS;
					ph_n = PH_SKIP;
				end
			end
			PH_META_BODY: begin
				res.delta_ticks = hdel;
				if ({1'b0, fbc} < {2'b0, meta_std_len(mt)}) begin
					cw_n = {cw[23:0], b}; fbc_n = fbc + 4'd1;
				end
				bbl_n = bbl_dec;
				if (bbl_dec == '0) begin
					res_valid = 1'b1;
					res.event_kind = mkind;
					res.status_code = mt;
					res.payload = (mkind == EV_TRK_END) ? 32'd0 : cw_n;
					ph_n = PH_DELTA;
					if (mkind == EV_TRK_END) begin
						vacc_n = '0; vcnt_n = '0; ph_n = PH_SKIP;
					end
				end
			end
			PH_SYSEX_LEN: begin
				vacc_n = vacc_sh; vcnt_n = vcnt_inc;
				res.delta_ticks = hdel;
				res.status_code = mt;
				if (vres == 2'd1) begin
					vacc_n = '0; vcnt_n = '0;
					bbl_n = {4'd0, vval}; cw_n = {4'd0, vval};
					if (vval == '0) begin
						res_valid = 1'b1;
						res.event_kind = EV_SKIPPED;
						ph_n = PH_DELTA;
					end else ph_n = PH_SYSEX_BODY;
				end else if (vres == 2'd2) begin
					vacc_n = '0; vcnt_n = '0;
					res_valid = 1'b1;
					res.event_kind = EV_VLQ_ERR;
					ph_n = PH_SKIP;
				end
			end
			PH_SYSEX_BODY: begin
				bbl_n = bbl_dec;
				if (bbl_dec == '0) begin
					res_valid = 1'b1;
					res.event_kind = EV_SKIPPED;
					res.delta_ticks = hdel;
					res.status_code = mt;
					res.payload = cw;
					ph_n = PH_DELTA;
				end
			end
			PH_SKIP: begin
				if (tbl_n == '0) vflag = 1'b1;
			end
			default: ph_n = PH_HALT;
		endcase

		// event end: spent budget or abandon goes to next track, or halts after the last track
		if ((ph_n == PH_DELTA || ph_n == PH_SKIP) && ph != PH_TRK_HDR && ph != PH_SKIP
			&& !(ph == PH_DELTA && ph_n == PH_DELTA) && tbl_n == '0) vflag = 1'b1;
		if (vflag) begin
			if (trl_n != '0) trl_n = trl_n - 16'd1;
			fbc_n = '0;
			ph_n = (trl_n == '0) ? PH_HALT : PH_TRK_HDR;
		end
		res_valid = res_valid & in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR; fbc_q <= '0; tbl_q <= '0; trl_q <= '0; vacc_q <= '0;
			vcnt_q <= '0; hdel_q <= '0; rs_q <= '0; mt_q <= '0; bbl_q <= '0;
			cw_q <= '0; hw_q <= '0;
		end else if (in_valid) begin
			phase_q <= ph_n; fbc_q <= fbc_n; tbl_q <= tbl_n; trl_q <= trl_n;
			vacc_q <= vacc_n; vcnt_q <= vcnt_n; hdel_q <= hdel_n; rs_q <= rs_n;
			mt_q <= mt_n; bbl_q <= bbl_n; cw_q <= cw_n; hw_q <= hw_n;
		end
	end

endmodule

// ===== hdl/mfsp_out_buf.sv =====
module mfsp_out_buf
	import mfsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_valid,
	input  result_t wr_data,
	output logic    wr_ready,
	output logic    rd_valid,
	input  logic    rd_ready,
	output result_t rd_data
);

	// two-entry skid: main output register plus one spare
	logic    full_q, spare_q;
	result_t main_q, skid_q;

	assign wr_ready = !spare_q;
	assign rd_valid = full_q;
	assign rd_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= 1'b0;
			spare_q <= 1'b0;
		end else begin
			if (!full_q || rd_ready) begin
				full_q  <= spare_q || wr_valid;
				spare_q <= 1'b0;
			end else if (wr_valid) begin
				spare_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!full_q || rd_ready) begin
			main_q <= spare_q ? skid_q : wr_data;
		end
		if (wr_valid && !spare_q) skid_q <= wr_data;
	end

endmodule

// ===== hdl/midi_file_stream_parser.sv =====
// midi file parser, one file byte per item
// input: s_axis_tdata carries the byte, s_axis_tuser the file start flag;
// raise file_start with the first byte of each file to restart parsing
// output: one result item per reported event on m_axis, packed as
// event_kind, delta_ticks, status_code, payload, division (lowest bit up)
// a result is registered in the output buffer from the byte that completes it
// throughput: one byte per cycle while s_axis_tready is high; the parse state register is updated
// by a single combinational pass per byte
// a two-entry output buffer lets bytes keep flowing while a result waits;
// s_axis_tready drops only when both entries are held by a stalled receiver
// reset: parser waits for the header, output buffer empty
// bytes after a halt or after the last track are consumed and dropped
module midi_file_stream_parser
	import mfsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // data_byte
	input  logic                   s_axis_tuser,  // file_start
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata   // kind, delta, status, payload, division
);

	logic    acc, res_valid, buf_ready;
	result_t res, out;

	assign s_axis_tready = buf_ready;
	assign acc = s_axis_tvalid && buf_ready;

	mfsp_core u_core (
		.clk(clk), .arst_n(arst_n), .in_valid(acc), .in_byte(s_axis_tdata),
		.in_start(s_axis_tuser), .res_valid(res_valid), .res(res)
	);

	mfsp_out_buf u_buf (
		.clk(clk), .arst_n(arst_n), .wr_valid(res_valid), .wr_data(res),
		.wr_ready(buf_ready), .rd_valid(m_axis_tvalid), .rd_ready(m_axis_tready),
		.rd_data(out)
	);

	assign m_axis_tdata = {out.division, out.payload, out.status_code,
		out.delta_ticks, out.event_kind};

`ifndef SYNTHESIS
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] <= EV_STATUS_ERR)
		else $error("bad event kind");
	a_div_only_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[3:0] != EV_HEADER) |-> m_axis_tdata[87:72] == 16'd0)
		else $error("division outside header");
	a_no_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |=> m_axis_tvalid)
		else $error("stall without pending result");
`endif

endmodule
